// File: rtl/core/lbus_pkg.sv
package lbus_pkg;

	// action codes
	localparam logic [1:0] ActUp   = 2'd0;
	localparam logic [1:0] ActDown = 2'd1;
	localparam logic [1:0] ActLeft = 2'd2;
	localparam logic [1:0] ActNone = 2'd3;

	// speed unit codes
	localparam logic [1:0] UnitMps = 2'd0;
	localparam logic [1:0] UnitKmh = 2'd1;
	localparam logic [1:0] UnitMph = 2'd2;

	// item kinds
	localparam logic KindButton = 1'b0;

	// register indexes
	localparam logic [1:0] RegDebounce = 2'd0;
	localparam logic [1:0] RegUpLimit  = 2'd1;
	localparam logic [1:0] RegDownLim  = 2'd2;
	localparam logic [1:0] RegLeftLim  = 2'd3;

	// register reset values
	localparam logic [15:0] DebounceRst = 16'd100;
	localparam logic [11:0] UpLimitRst  = 12'd900;
	localparam logic [11:0] DownLimRst  = 12'd2000;
	localparam logic [11:0] LeftLimRst  = 12'd3000;

	// km/h: q8*36/2560 = ((q8*36) >> 9) / 5
	localparam logic [5:0]  KmhNum     = 6'd36;
	localparam logic [12:0] KmhSatLim  = 13'd1280;   // 5 * 256
	localparam logic [13:0] KmhRecip   = 14'd13108;  // ceil(2^16 / 5)
	// mph: q8*2237/256000 = ((q8*2237) >> 11) / 125
	localparam logic [11:0] MphNum     = 12'd2237;
	localparam logic [16:0] MphSatLim  = 17'd32000;  // 125 * 256
	localparam logic [15:0] MphRecip   = 16'd33555;  // ceil(2^22 / 125)
	// decimal split: w/10 = (w*205) >> 11 for w < 1029
	localparam logic [7:0]  TenRecip   = 8'd205;

	typedef struct packed {
		logic       kind;
		logic [1:0] action;
		logic [1:0] unit_now;
		logic       mode_now;
	} lbus_ctl_t;

endpackage

// File: rtl/core/ladder_button_unit_speed_bcd_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | kind, adc_sample, tick_ms, speed_q8
// out      | out_valid / out_stall| action, unit_now, mode_now, speed_whole,
//          |                      | speed_bcd, over_two_digits
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One item per cycle unless a stalled result holds the pipeline; each result passes
// through the input register, unit scale multiply, reciprocal divide and BCD split/output stages.
// Button decode and state update happen in the first stage, so the next item
// already sees the new unit, mode and press time.
// arst_n clears all valid bits, the unit, mode and press time, and loads the registers with their reset values.
// All stages move together: a stalled result holds the whole pipeline and
// raises in_stall in the same cycle.
module ladder_button_unit_speed_bcd_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [11:0] adc_sample,
	input  logic [31:0] tick_ms,
	input  logic [15:0] speed_q8,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [1:0]  unit_now,
	output logic        mode_now,
	output logic [7:0]  speed_whole,
	output logic [7:0]  speed_bcd,
	output logic        over_two_digits,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        adv;

	logic [15:0] debounce_q;
	logic [11:0] up_limit_q;
	logic [11:0] down_limit_q;
	logic [11:0] left_limit_q;

	logic [1:0]  speed_unit_q;
	logic        display_q;
	logic [31:0] last_press_q;

	logic        v_s1;
	logic        kind_s1;
	logic [11:0] adc_s1;
	logic [31:0] tick_s1;
	logic [15:0] q8_s1;

	logic                v_s2;
	lbus_pkg::lbus_ctl_t ctl_s2;
	logic [1:0]          scale_s2;
	logic [16:0]         y_s2;

	logic                v_s3;
	lbus_pkg::lbus_ctl_t ctl_s3;
	logic [7:0]          whole_s3;

	logic                out_valid_q;
	lbus_pkg::lbus_ctl_t ctl_q;
	logic [7:0]          whole_q;
	logic [7:0]          bcd_q;
	logic                over_q;

	// stage 1 decode
	logic [31:0] elapsed;
	logic        debounce_ok;
	logic        hit_up, hit_down, hit_left;
	logic [1:0]  act_s1;
	logic [1:0]  unit_next;
	logic        mode_next;
	logic [21:0] kmh_prod;
	logic [27:0] mph_prod;
	logic [16:0] y_s1;

	// stage 2 divide
	logic [24:0] kmh_quot;
	logic [30:0] mph_quot;
	logic [7:0]  whole_s2;

	// stage 3 split
	logic [15:0] ten_prod;
	logic [4:0]  tens;
	logic [7:0]  ones_full;

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= lbus_pkg::DebounceRst;
			up_limit_q   <= lbus_pkg::UpLimitRst;
			down_limit_q <= lbus_pkg::DownLimRst;
			left_limit_q <= lbus_pkg::LeftLimRst;
		end else if (cfg_we) begin
			case (cfg_index)
				lbus_pkg::RegDebounce: debounce_q   <= cfg_data;
				lbus_pkg::RegUpLimit:  up_limit_q   <= cfg_data[11:0];
				lbus_pkg::RegDownLim:  down_limit_q <= cfg_data[11:0];
				lbus_pkg::RegLeftLim:  left_limit_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			adc_s1  <= adc_sample;
			tick_s1 <= tick_ms;
			q8_s1   <= speed_q8;
		end
	end

	// button decode against debounce window and ladder bands
	always_comb begin
		elapsed     = tick_s1 - last_press_q;
		debounce_ok = elapsed >= {16'd0, debounce_q};
		hit_up      = (adc_s1 != 12'd0) && (adc_s1 < up_limit_q);
		hit_down    = (adc_s1 >= up_limit_q) && (adc_s1 < down_limit_q);
		hit_left    = (adc_s1 >= down_limit_q) && (adc_s1 < left_limit_q);
		act_s1      = lbus_pkg::ActNone;
		unit_next   = speed_unit_q;
		mode_next   = display_q;
		if (kind_s1 == lbus_pkg::KindButton && debounce_ok) begin
			if (hit_up) begin
				act_s1    = lbus_pkg::ActUp;
				mode_next = 1'b0;
			end else if (hit_down) begin
				act_s1    = lbus_pkg::ActDown;
				mode_next = 1'b1;
			end else if (hit_left) begin
				act_s1 = lbus_pkg::ActLeft;
				if (speed_unit_q == lbus_pkg::UnitMph) begin
					unit_next = lbus_pkg::UnitMps;
				end else begin
					unit_next = speed_unit_q + 2'd1;
				end
			end
		end
	end

	// scale by the unit numerator and drop the power-of-two part
	always_comb begin
		kmh_prod = 22'(q8_s1) * 22'(lbus_pkg::KmhNum);
		mph_prod = 28'(q8_s1) * 28'(lbus_pkg::MphNum);
		case (speed_unit_q)
			lbus_pkg::UnitKmh: y_s1 = 17'(kmh_prod[21:9]);
			lbus_pkg::UnitMph: y_s1 = mph_prod[27:11];
			default:           y_s1 = 17'(q8_s1[15:8]);
		endcase
	end

	// state update on transfer out of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_unit_q <= lbus_pkg::UnitMps;
			display_q    <= 1'b0;
			last_press_q <= 32'd0;
		end else if (adv && v_s1) begin
			speed_unit_q <= unit_next;
			display_q    <= mode_next;
			if (act_s1 != lbus_pkg::ActNone) begin
				last_press_q <= tick_s1;
			end
		end
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2.kind     <= kind_s1;
			ctl_s2.action   <= act_s1;
			ctl_s2.unit_now <= unit_next;
			ctl_s2.mode_now <= mode_next;
			scale_s2        <= speed_unit_q;
			y_s2            <= y_s1;
		end
	end

	// for km/h and mph divide by the odd factor through a reciprocal, saturate at 255; button items give zero
	always_comb begin
		kmh_quot = 25'(y_s2[10:0]) * 25'(lbus_pkg::KmhRecip);
		mph_quot = 31'(y_s2[14:0]) * 31'(lbus_pkg::MphRecip);
		case (scale_s2)
			lbus_pkg::UnitKmh: begin
				if (y_s2[12:0] >= lbus_pkg::KmhSatLim) begin
					whole_s2 = 8'd255;
				end else begin
					whole_s2 = kmh_quot[23:16];
				end
			end
			lbus_pkg::UnitMph: begin
				if (y_s2 >= lbus_pkg::MphSatLim) begin
					whole_s2 = 8'd255;
				end else begin
					whole_s2 = mph_quot[29:22];
				end
			end
			default: whole_s2 = y_s2[7:0];
		endcase
		if (ctl_s2.kind == lbus_pkg::KindButton) begin
			whole_s2 = 8'd0;
		end
	end

	// stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3   <= ctl_s2;
			whole_s3 <= whole_s2;
		end
	end

	// split into tens and ones
	always_comb begin
		ten_prod  = 16'(whole_s3) * 16'(lbus_pkg::TenRecip);
		tens      = ten_prod[15:11];
		ones_full = whole_s3 - {tens[4:0], 3'b000} - {2'b00, tens[4:0], 1'b0};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_q   <= ctl_s3;
			whole_q <= whole_s3;
			bcd_q   <= {tens[3:0], ones_full[3:0]};
			over_q  <= whole_s3 > 8'd99;
		end
	end

	assign action          = ctl_q.action;
	assign unit_now        = ctl_q.unit_now;
	assign mode_now        = ctl_q.mode_now;
	assign speed_whole     = whole_q;
	assign speed_bcd       = bcd_q;
	assign over_two_digits = over_q;

endmodule
